@@ hdl/dhr_pkg.sv @@
// shared types, constants and arithmetic helpers for the dense regression layer
`timescale 1ns / 1ps
`default_nettype none
package dhr_pkg;

    localparam int LAYER_N   = 16;
    localparam int HALF_N    = LAYER_N / 2;
    localparam int IDX_W     = 4;
    localparam int HALF_W    = $clog2(HALF_N);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int EXP_DEPTH = 256;
    localparam int EXP_BITS  = $clog2(EXP_DEPTH);
    localparam longint LN2_Q30  = 64'sd744261118;
    localparam longint LN2_HALF = 64'sd372130559;

    typedef enum logic [2:0] {
        OP_WEIGHT      = 3'd0,
        OP_BIAS        = 3'd1,
        OP_INPUT       = 3'd2,
        OP_FORWARD     = 3'd3,
        OP_TARGET      = 3'd4,
        OP_BACKWARD    = 3'd5,
        OP_READ_GRAD   = 3'd6,
        OP_CLEAR_GRADS = 3'd7
    } op_t;

    localparam logic [1:0] KIND_FORWARD = 2'd0;
    localparam logic [1:0] KIND_LOSS    = 2'd1;
    localparam logic [1:0] KIND_GRAD    = 2'd2;

    localparam logic [1:0] GSEL_WEIGHT = 2'd0;
    localparam logic [1:0] GSEL_BIAS   = 2'd1;
    localparam logic [1:0] GSEL_INPUT  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_MAC,
        ST_FWD_OUT,
        ST_BWD_DY,
        ST_BWD_GM,
        ST_BWD_E2,
        ST_BWD_GS,
        ST_BWD_P0,
        ST_BWD_P1,
        ST_BWD_P2,
        ST_BWD_P3,
        ST_BWD_P4,
        ST_BWD_LOSS,
        ST_GRD_RD,
        ST_GRD_OUT
    } state_t;

    typedef struct packed {
        logic             wr_weight;
        logic             wr_bias;
        logic             wr_input;
        logic             wr_target;
        logic             clr_grads;
        logic             fwd_init;
        logic             fwd_mac;
        logic             fwd_out;
        logic             fwd_last;
        logic             bwd_init;
        logic             bwd_dy;
        logic             bwd_gm;
        logic             bwd_e2;
        logic             bwd_gs;
        logic             bwd_p1;
        logic             bwd_p2;
        logic             bwd_p3;
        logic             bwd_p4;
        logic             bwd_loss;
        logic             grd_out;
        logic             rd_hi;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [1:0]       sel;
    } cmd_t;

    typedef logic [EXP_DEPTH-1:0][31:0] exp_table_t;

    // shift and subtract division, rounded toward zero, for building the table
    function automatic longint div_trunc(input longint num, input longint den);
        longint mag;
        longint quo;
        longint rem;
        int b;
        mag = (num < 0) ? -num : num;
        quo = 0;
        rem = 0;
        for (b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'sd1 <<< b);
            end
        end
        return (num < 0) ? -quo : quo;
    endfunction

    // exp(-x) at the lower edge of each cell, as 2^n * e^r with a taylor series
    function automatic exp_table_t build_exp_table();
        exp_table_t tab;
        longint t;
        longint n;
        longint r;
        longint sum;
        longint term;
        longint res;
        longint s;
        int k;
        int i;
        for (k = 0; k < EXP_DEPTH; k++)
        begin
            t = ((64'sd8 * EXP_DEPTH) - 64'sd16 * k) * (64'sd1 <<< 30) >>> EXP_BITS;
            n = 0;
            while (t - n * LN2_Q30 > LN2_HALF)
                n++;
            while (t - n * LN2_Q30 < -LN2_HALF)
                n--;
            r = t - n * LN2_Q30;
            sum = 64'sd1 <<< 30;
            term = 64'sd1 <<< 30;
            for (i = 1; i <= 10; i++)
            begin
                term = div_trunc(term * r, longint'(i) <<< 30);
                sum = sum + term;
            end
            s = 14 - n;
            if (s < 1)
                s = 1;
            if (s > 40)
                s = 40;
            res = (sum + (64'sd1 <<< (s - 1))) >>> s;
            tab[k] = res[31:0];
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

    function automatic logic signed [63:0] ext64(input logic signed [31:0] a);
        return {{32{a[31]}}, a};
    endfunction

    function automatic logic signed [31:0] ext32(input logic signed [15:0] a);
        return {{16{a[15]}}, a};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(ext64(a) + ext64(b));
    endfunction

endpackage
`default_nettype wire

@@ hdl/dense_heteroscedastic_regression.sv @@
// top level of the dense layer with heteroscedastic gaussian loss
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  item in   | start, busy            | operation, row_index, col_index, value,
//            |                        | grad_select
//  result    | result_valid (strobe)  | result_kind, result_index, result_value, last
//
// a transaction is taken on a rising edge with start high and busy low
// loads, target writes and clear grads leave busy low
// forward: per row, a read state and a multiply-accumulate state for each weight, then an output state
//   (single weight memory read port plus the shared multiplier)
// backward: per mean row the dy, gm, e2 and gs steps, then steps p0 to p4 per column on one multiplier
// gradient read: busy through a read state and an output state (registered gradient memory read)
// each result is a one-cycle strobe from the output register, the receiver cannot stall
// reset is asynchronous active low and clears outputs, gradients and valid bits
`timescale 1ns / 1ps
`default_nettype none
module dense_heteroscedastic_regression (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [2:0]                operation,
    input  wire logic [dhr_pkg::IDX_W-1:0] row_index,
    input  wire logic [dhr_pkg::IDX_W-1:0] col_index,
    input  wire logic signed [15:0]        value,
    input  wire logic [1:0]                grad_select,
    output logic                           result_valid,
    output logic [1:0]                     result_kind,
    output logic [dhr_pkg::IDX_W-1:0]      result_index,
    output logic signed [31:0]             result_value,
    output logic                           last
);
    import dhr_pkg::*;

    // command bundle from sequencer to datapath
    cmd_t cmd;

    // controller walks rows and columns and times each step of a transaction
    dhr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .operation   (operation),
        .row_index   (row_index),
        .col_index   (col_index),
        .grad_select (grad_select),
        .busy        (busy),
        .cmd         (cmd)
    );

    // datapath holds the stores, the multiplier and the result register
    dhr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .result_index (result_index),
        .result_value (result_value),
        .last         (last)
    );

    // a forward or backward transaction always makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_FORWARD || operation == OP_BACKWARD) |=> busy)
        else $error("sweep did not start");

    // the final result of a transaction is never followed directly by another
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result right after last");

    // the loss is a single result and so always carries last
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_LOSS |-> last)
        else $error("loss without last");

endmodule
`default_nettype wire

@@ hdl/dhr_ctrl.sv @@
// sequencer for loads, forward sweep, backward sweep and gradient reads
`timescale 1ns / 1ps
`default_nettype none
module dhr_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [2:0]               operation,
    input  wire logic [dhr_pkg::IDX_W-1:0] row_index,
    input  wire logic [dhr_pkg::IDX_W-1:0] col_index,
    input  wire logic [1:0]               grad_select,
    output logic                          busy,
    output dhr_pkg::cmd_t                 cmd
);
    import dhr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAYER_N - 1);
    localparam logic [IDX_W-1:0] LAST_HALF = IDX_W'(HALF_N - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [1:0]       sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.row    = i_reg;
        cmd.col    = j_reg;
        cmd.sel    = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.row = row_index;
                cmd.col = col_index;
                if (start)
                begin
                    case (op_t'(operation))
                        OP_WEIGHT:
                            cmd.wr_weight = (int'(row_index) < LAYER_N) &&
                                            (int'(col_index) < LAYER_N);
                        OP_BIAS:
                            cmd.wr_bias = (int'(row_index) < LAYER_N);
                        OP_INPUT:
                            cmd.wr_input = (int'(col_index) < LAYER_N);
                        OP_TARGET:
                            cmd.wr_target = (int'(row_index) < HALF_N);
                        OP_CLEAR_GRADS:
                            cmd.clr_grads = 1'b1;
                        OP_FORWARD:
                        begin
                            cmd.fwd_init = 1'b1;
                            i_next       = '0;
                            j_next       = '0;
                            state_next   = ST_FWD_RD;
                        end
                        OP_BACKWARD:
                        begin
                            cmd.bwd_init = 1'b1;
                            i_next       = '0;
                            j_next       = '0;
                            state_next   = ST_BWD_DY;
                        end
                        OP_READ_GRAD:
                        begin
                            i_next     = row_index;
                            j_next     = col_index;
                            sel_next   = grad_select;
                            state_next = ST_GRD_RD;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FWD_RD:
                state_next = ST_FWD_MAC;
            ST_FWD_MAC:
            begin
                cmd.fwd_mac = 1'b1;
                if (j_reg == LAST_IDX)
                begin
                    j_next     = '0;
                    state_next = ST_FWD_OUT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FWD_RD;
                end
            end
            ST_FWD_OUT:
            begin
                cmd.fwd_out  = 1'b1;
                cmd.fwd_last = (i_reg == LAST_IDX);
                if (i_reg == LAST_IDX)
                    state_next = ST_IDLE;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_FWD_RD;
                end
            end
            ST_BWD_DY:
            begin
                cmd.bwd_dy = 1'b1;
                state_next = ST_BWD_GM;
            end
            ST_BWD_GM:
            begin
                cmd.bwd_gm = 1'b1;
                state_next = ST_BWD_E2;
            end
            ST_BWD_E2:
            begin
                cmd.bwd_e2 = 1'b1;
                state_next = ST_BWD_GS;
            end
            ST_BWD_GS:
            begin
                cmd.bwd_gs = 1'b1;
                state_next = ST_BWD_P0;
            end
            ST_BWD_P0:
                state_next = ST_BWD_P1;
            ST_BWD_P1:
            begin
                cmd.bwd_p1 = 1'b1;
                state_next = ST_BWD_P2;
            end
            ST_BWD_P2:
            begin
                cmd.bwd_p2 = 1'b1;
                cmd.rd_hi  = 1'b1;
                state_next = ST_BWD_P3;
            end
            ST_BWD_P3:
            begin
                cmd.bwd_p3 = 1'b1;
                cmd.rd_hi  = 1'b1;
                state_next = ST_BWD_P4;
            end
            ST_BWD_P4:
            begin
                cmd.bwd_p4 = 1'b1;
                cmd.rd_hi  = 1'b1;
                if (j_reg == LAST_IDX)
                begin
                    j_next = '0;
                    if (i_reg == LAST_HALF)
                        state_next = ST_BWD_LOSS;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_BWD_DY;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_BWD_P0;
                end
            end
            ST_BWD_LOSS:
            begin
                cmd.bwd_loss = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_GRD_RD:
                state_next = ST_GRD_OUT;
            ST_GRD_OUT:
            begin
                cmd.grd_out = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/dhr_datapath.sv @@
// stores, shared multiplier, accumulators and result register
`timescale 1ns / 1ps
`default_nettype none
module dhr_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dhr_pkg::cmd_t      cmd,
    input  wire logic signed [15:0] value,
    output logic                    result_valid,
    output logic [1:0]              result_kind,
    output logic [dhr_pkg::IDX_W-1:0] result_index,
    output logic signed [31:0]      result_value,
    output logic                    last
);
    import dhr_pkg::*;

    localparam int MEM_DEPTH = LAYER_N * LAYER_N;

    logic signed [15:0] weight_mem [MEM_DEPTH];
    logic signed [31:0] wgrad_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] wgrad_vld_reg;

    logic signed [15:0] bias_reg [LAYER_N];
    logic signed [15:0] input_reg [LAYER_N];
    logic signed [15:0] target_reg [HALF_N];
    logic signed [31:0] out_reg [LAYER_N];
    logic signed [31:0] bgrad_reg [LAYER_N];
    logic signed [31:0] igrad_reg [LAYER_N];

    logic signed [15:0] wq_reg;
    logic signed [31:0] gq_reg;
    logic               gvq_reg;
    logic signed [39:0] acc_reg;
    logic signed [31:0] dy_reg, lv_reg, prec_reg, gm_reg, e2_reg, gs_reg, loss_reg;

    logic               res_valid_reg;
    logic [1:0]         res_kind_reg;
    logic [IDX_W-1:0]   res_index_reg;
    logic signed [31:0] res_value_reg;
    logic               res_last_reg;

    logic [IDX_W-1:0]   hi_row, rd_row, wr_row;
    logic [ADDR_W-1:0]  rd_addr, wr_addr, ld_addr;
    logic signed [15:0] x_cur;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [31:0] scaled16, scaled12;
    logic signed [31:0] g_old, g_new, igrad_new;
    logic signed [39:0] acc_shift;
    logic signed [31:0] fwd_val;
    logic signed [31:0] dy_val, lv_val, out_hi;
    logic [31:0]        lv_off;
    logic [EXP_BITS-1:0] exp_idx;
    logic signed [31:0] gs_val, loss_term, grad_val;

    assign hi_row  = cmd.row + IDX_W'(HALF_N);
    assign rd_row  = cmd.rd_hi ? hi_row : cmd.row;
    assign wr_row  = cmd.bwd_p4 ? hi_row : cmd.row;
    assign rd_addr = {rd_row, cmd.col};
    assign wr_addr = {wr_row, cmd.col};
    assign ld_addr = {cmd.row, cmd.col};
    assign x_cur   = input_reg[cmd.col];

    // one shared signed multiplier, operands picked by the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.fwd_mac)
        begin
            mul_a = ext32(x_cur);
            mul_b = ext32(wq_reg);
        end
        else if (cmd.bwd_gm)
        begin
            mul_a = prec_reg;
            mul_b = dy_reg;
        end
        else if (cmd.bwd_e2)
        begin
            mul_a = gm_reg;
            mul_b = dy_reg;
        end
        else if (cmd.bwd_p1)
        begin
            mul_a = gm_reg;
            mul_b = ext32(wq_reg);
        end
        else if (cmd.bwd_p2)
        begin
            mul_a = gm_reg;
            mul_b = ext32(x_cur);
        end
        else if (cmd.bwd_p3)
        begin
            mul_a = gs_reg;
            mul_b = ext32(wq_reg);
        end
        else if (cmd.bwd_p4)
        begin
            mul_a = gs_reg;
            mul_b = ext32(x_cur);
        end
    end

    assign prod     = mul_a * mul_b;
    assign scaled16 = sat32(prod >>> 16);
    assign scaled12 = sat32(prod >>> 12);

    assign g_old     = gvq_reg ? gq_reg : 32'sd0;
    assign g_new     = add_sat(g_old, scaled12);
    assign igrad_new = add_sat(igrad_reg[cmd.col], scaled12);

    assign acc_shift = acc_reg >>> 8;
    assign fwd_val   = sat32({{24{acc_shift[39]}}, acc_shift} +
                             {{44{bias_reg[cmd.row][15]}}, bias_reg[cmd.row], 4'b0});

    assign dy_val = sat32(ext64(out_reg[cmd.row]) -
                          {{44{target_reg[cmd.row[HALF_W-1:0]][15]}},
                           target_reg[cmd.row[HALF_W-1:0]], 4'b0});
    assign out_hi = out_reg[hi_row];

    // log variance clamped to [-8, 8) before the table lookup
    always_comb
    begin
        if (out_hi < -32'sd524288)
            lv_val = -32'sd524288;
        else if (out_hi > 32'sd524287)
            lv_val = 32'sd524287;
        else
            lv_val = out_hi;
    end

    assign lv_off  = lv_val + 32'sd524288;
    assign exp_idx = lv_off[19 -: EXP_BITS];

    assign gs_val    = sat32((64'sd65536 - ext64(e2_reg)) >>> 1);
    assign loss_term = sat32((ext64(e2_reg) + ext64(lv_reg)) >>> 1);

    always_comb
    begin
        case (cmd.sel)
            GSEL_WEIGHT: grad_val = g_old;
            GSEL_BIAS:   grad_val = bgrad_reg[cmd.row];
            GSEL_INPUT:  grad_val = igrad_reg[cmd.col];
            default:     grad_val = 32'sd0;
        endcase
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_weight)
            weight_mem[ld_addr] <= value;
        wq_reg <= weight_mem[rd_addr];
    end

    // weight gradient store
    always_ff @(posedge clk)
    begin
        if (cmd.bwd_p2 || cmd.bwd_p4)
            wgrad_mem[wr_addr] <= g_new;
        gq_reg <= wgrad_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gvq_reg <= 1'b0;
        else
            gvq_reg <= wgrad_vld_reg[rd_addr];
    end

    // state with a defined reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgrad_vld_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int n = 0; n < LAYER_N; n++)
            begin
                out_reg[n]   <= '0;
                bgrad_reg[n] <= '0;
                igrad_reg[n] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= cmd.fwd_out | cmd.bwd_loss | cmd.grd_out;
            if (cmd.clr_grads)
            begin
                wgrad_vld_reg <= '0;
                for (int n = 0; n < LAYER_N; n++)
                begin
                    bgrad_reg[n] <= '0;
                    igrad_reg[n] <= '0;
                end
            end
            if (cmd.bwd_init)
            begin
                for (int n = 0; n < LAYER_N; n++)
                    igrad_reg[n] <= '0;
            end
            if (cmd.bwd_p2 || cmd.bwd_p4)
                wgrad_vld_reg[wr_addr] <= 1'b1;
            if (cmd.bwd_p1 || cmd.bwd_p3)
                igrad_reg[cmd.col] <= igrad_new;
            if (cmd.bwd_gs)
            begin
                bgrad_reg[cmd.row] <= add_sat(bgrad_reg[cmd.row], gm_reg);
                bgrad_reg[hi_row]  <= add_sat(bgrad_reg[hi_row], gs_val);
            end
            if (cmd.fwd_out)
                out_reg[cmd.row] <= fwd_val;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.wr_bias)
            bias_reg[cmd.row] <= value;
        if (cmd.wr_input)
            input_reg[cmd.col] <= value;
        if (cmd.wr_target)
            target_reg[cmd.row[HALF_W-1:0]] <= value;
        if (cmd.fwd_init || cmd.fwd_out)
            acc_reg <= '0;
        else if (cmd.fwd_mac)
            acc_reg <= acc_reg + prod[39:0];
        if (cmd.bwd_init)
            loss_reg <= '0;
        else if (cmd.bwd_gs)
            loss_reg <= add_sat(loss_reg, loss_term);
        if (cmd.bwd_dy)
        begin
            dy_reg   <= dy_val;
            lv_reg   <= lv_val;
            prec_reg <= EXP_TABLE[exp_idx];
        end
        if (cmd.bwd_gm)
            gm_reg <= scaled16;
        if (cmd.bwd_e2)
            e2_reg <= scaled16;
        if (cmd.bwd_gs)
            gs_reg <= gs_val;
        if (cmd.fwd_out)
        begin
            res_kind_reg  <= KIND_FORWARD;
            res_index_reg <= cmd.row;
            res_value_reg <= fwd_val;
            res_last_reg  <= cmd.fwd_last;
        end
        else if (cmd.bwd_loss)
        begin
            res_kind_reg  <= KIND_LOSS;
            res_index_reg <= '0;
            res_value_reg <= loss_reg;
            res_last_reg  <= 1'b1;
        end
        else
        begin
            res_kind_reg  <= KIND_GRAD;
            res_index_reg <= '0;
            res_value_reg <= grad_val;
            res_last_reg  <= 1'b1;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign result_index = res_index_reg;
    assign result_value = res_value_reg;
    assign last         = res_last_reg;

endmodule
`default_nettype wire

@@ tb/dense_heteroscedastic_regression_test.sv @@
// testbench for the dense heteroscedastic regression layer: store fill, directed table, random items
`timescale 1ns / 1ps
`default_nettype none
module dense_heteroscedastic_regression_test;
    import dhr_pkg::*;

    localparam int N        = 16;
    localparam int H        = N / 2;
    localparam int RAND_CNT = 16;
    localparam int SETUP_CNT = N * N + 2 * N + H;
    localparam logic [1:0] GSEL_NONE = 2'd3;

    // one expected result transaction
    typedef struct {
        logic [1:0]         kind;
        logic [3:0]         index;
        logic signed [31:0] val;
        logic               last;
    } layer_result_t;

    // one directed row; fixed rows carry the expected gradient read value
    typedef struct {
        op_t                op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] val;
        logic [1:0]         sel;
        bit                 fixed;
        logic signed [31:0] fixed_val;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         operation;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] value;
    logic [1:0]         grad_select;
    logic               result_valid;
    logic [1:0]         result_kind;
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               last;

    dense_heteroscedastic_regression dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .row_index   (row_index),
        .col_index   (col_index),
        .value       (value),
        .grad_select (grad_select),
        .result_valid(result_valid),
        .result_kind (result_kind),
        .result_index(result_index),
        .result_value(result_value),
        .last        (last)
    );

    // shadow copy of the layer state
    logic signed [15:0] w_mem [N*N];
    logic signed [15:0] b_mem [N];
    logic signed [15:0] x_mem [N];
    logic signed [15:0] t_mem [H];
    logic signed [31:0] y_mem [N];
    logic signed [31:0] wg_mem [N*N];
    logic signed [31:0] bg_mem [N];
    logic signed [31:0] xg_mem [N];
    logic signed [31:0] exp_lut [256];

    layer_result_t pending_results[$];
    int            error_count;
    int            items_sent;
    int            idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sum_clip(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    // q16.16 times q4.12, floored
    function automatic logic signed [31:0] scale_q12(input logic signed [31:0] a,
                                                     input logic signed [15:0] b);
        return clip32((longint'(a) * longint'(b)) >>> 12);
    endfunction

    function automatic logic signed [31:0] scale_q16(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        return clip32((longint'(a) * longint'(b)) >>> 16);
    endfunction

    // exp(-x) at each cell edge: split into 2^n * e^r, taylor series in q30
    function automatic logic signed [31:0] neg_exp_entry(input int k);
        longint ln2;
        longint x;
        longint n;
        longint r;
        longint acc;
        longint term;
        longint sh;
        ln2 = 64'sd744261118;
        x = (64'sd2048 - 64'sd16 * k) * (64'sd1 <<< 30) / 256;
        n = 0;
        while (x - n * ln2 > ln2 / 2)
            n++;
        while (x - n * ln2 < -(ln2 / 2))
            n--;
        r = x - n * ln2;
        acc = 64'sd1 <<< 30;
        term = 64'sd1 <<< 30;
        for (int i = 1; i <= 10; i++)
        begin
            term = term * r / (longint'(i) <<< 30);
            acc += term;
        end
        sh = 14 - n;
        if (sh < 1)
            sh = 1;
        if (sh > 40)
            sh = 40;
        acc = (acc + (64'sd1 <<< (sh - 1))) >> sh;
        return acc[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_lv(input logic signed [31:0] v);
        if (v < -(32'sd8 <<< 16))
            return -(32'sd8 <<< 16);
        if (v > (32'sd8 <<< 16) - 1)
            return (32'sd8 <<< 16) - 1;
        return v;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [3:0] idx,
                                        input logic signed [31:0] v, input logic lst);
        layer_result_t r;
        r.kind = kind;
        r.index = idx;
        r.val = v;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    // advance the shadow state by one transaction and queue what it emits
    function automatic void predict_layer(input op_t op, input logic [3:0] row,
                                          input logic [3:0] col,
                                          input logic signed [15:0] v,
                                          input logic [1:0] sel);
        longint             acc;
        logic signed [31:0] loss;
        logic signed [31:0] dy;
        logic signed [31:0] lv;
        logic signed [31:0] prec;
        logic signed [31:0] gm;
        logic signed [31:0] e2;
        logic signed [31:0] gs;
        logic signed [31:0] g;
        longint             k;
        case (op)
            OP_WEIGHT:
                w_mem[row * N + col] = v;
            OP_BIAS:
                b_mem[row] = v;
            OP_INPUT:
                x_mem[col] = v;
            OP_TARGET:
                if (row < H)
                    t_mem[row] = v;
            OP_FORWARD:
                for (int i = 0; i < N; i++)
                begin
                    acc = 0;
                    for (int j = 0; j < N; j++)
                        acc += longint'(x_mem[j]) * longint'(w_mem[i * N + j]);
                    y_mem[i] = clip32((acc >>> 8) + longint'(b_mem[i]) * 16);
                    push_result(KIND_FORWARD, i[3:0], y_mem[i], i == N - 1);
                end
            OP_BACKWARD:
            begin
                loss = 0;
                for (int j = 0; j < N; j++)
                    xg_mem[j] = 0;
                for (int i = 0; i < H; i++)
                begin
                    dy = clip32(longint'(y_mem[i]) - longint'(t_mem[i]) * 16);
                    lv = clamp_lv(y_mem[i + H]);
                    k = ((longint'(lv) + (64'sd8 <<< 16)) * 256) >>> 20;
                    prec = exp_lut[k];
                    gm = scale_q16(prec, dy);
                    e2 = scale_q16(gm, dy);
                    gs = clip32((64'sd65536 - longint'(e2)) >>> 1);
                    for (int j = 0; j < N; j++)
                    begin
                        xg_mem[j] = sum_clip(xg_mem[j], scale_q12(gm, w_mem[i * N + j]));
                        xg_mem[j] = sum_clip(xg_mem[j], scale_q12(gs, w_mem[(i + H) * N + j]));
                        wg_mem[i * N + j] = sum_clip(wg_mem[i * N + j], scale_q12(gm, x_mem[j]));
                        wg_mem[(i + H) * N + j] =
                            sum_clip(wg_mem[(i + H) * N + j], scale_q12(gs, x_mem[j]));
                    end
                    bg_mem[i] = sum_clip(bg_mem[i], gm);
                    bg_mem[i + H] = sum_clip(bg_mem[i + H], gs);
                    loss = sum_clip(loss, clip32((longint'(e2) + longint'(lv)) >>> 1));
                end
                push_result(KIND_LOSS, 4'd0, loss, 1'b1);
            end
            OP_READ_GRAD:
            begin
                g = 0;
                if (sel == GSEL_WEIGHT)
                    g = wg_mem[row * N + col];
                else if (sel == GSEL_BIAS)
                    g = bg_mem[row];
                else if (sel == GSEL_INPUT)
                    g = xg_mem[col];
                push_result(KIND_GRAD, 4'd0, g, 1'b1);
            end
            default:
                for (int j = 0; j < N * N; j++)
                begin
                    wg_mem[j] = 0;
                    if (j < N)
                    begin
                        bg_mem[j] = 0;
                        xg_mem[j] = 0;
                    end
                end
        endcase
    endfunction

    // sender idles at random, then holds start until the block takes the transaction
    task automatic issue_item(input op_t op, input logic [3:0] row, input logic [3:0] col,
                              input logic signed [15:0] v, input logic [1:0] sel);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        row_index   <= row;
        col_index   <= col;
        value       <= v;
        grad_select <= sel;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_layer(op, row, col, v, sel);
        items_sent++;
        // phases of sender idling: none, heavy, none, moderate
        case ((items_sent * 4) / (SETUP_CNT + RAND_CNT + 25))
            0:       idle_pct = 0;
            1:       idle_pct = 63;
            2:       idle_pct = 0;
            default: idle_pct = 38;
        endcase
    endtask

    // result monitor: every strobe must match the oldest pending result
    always @(posedge clk)
    begin
        layer_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, value", result_value, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (result_index !== want.index)
                    report_mismatch("result_index", result_index, want.index);
                if (result_value !== want.val)
                    report_mismatch("result_value", result_value, want.val);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    stim_row_t directed_rows[] = '{
        // gradients read as zero after reset
        '{OP_READ_GRAD,   4'd0,  4'd0,  16'sd0,      GSEL_WEIGHT, 1, 0},
        '{OP_READ_GRAD,   4'd5,  4'd9,  16'sd0,      GSEL_NONE,   1, 0},
        '{OP_READ_GRAD,   4'd15, 4'd0,  16'sd0,      GSEL_BIAS,   1, 0},
        '{OP_READ_GRAD,   4'd0,  4'd15, 16'sd0,      GSEL_INPUT,  1, 0},
        // value extremes in every store
        '{OP_WEIGHT,      4'd15, 4'd15, 16'sh7FFF,   GSEL_WEIGHT, 0, 0},
        '{OP_WEIGHT,      4'd0,  4'd0,  16'sh8000,   GSEL_WEIGHT, 0, 0},
        '{OP_BIAS,        4'd15, 4'd0,  16'sh7FFF,   GSEL_WEIGHT, 0, 0},
        '{OP_BIAS,        4'd0,  4'd0,  16'sh8000,   GSEL_WEIGHT, 0, 0},
        '{OP_INPUT,       4'd0,  4'd15, 16'sh7FFF,   GSEL_WEIGHT, 0, 0},
        '{OP_INPUT,       4'd0,  4'd0,  16'sh8000,   GSEL_WEIGHT, 0, 0},
        '{OP_TARGET,      4'd7,  4'd0,  16'sh7FFF,   GSEL_WEIGHT, 0, 0},
        '{OP_TARGET,      4'd0,  4'd0,  16'sh8000,   GSEL_WEIGHT, 0, 0},
        // target beyond the means is ignored
        '{OP_TARGET,      4'd12, 4'd0,  16'sd1234,   GSEL_WEIGHT, 0, 0},
        // backward before any forward sees all-zero outputs
        '{OP_BACKWARD,    4'd0,  4'd0,  16'sd0,      GSEL_WEIGHT, 0, 0},
        '{OP_FORWARD,     4'd0,  4'd0,  16'sd0,      GSEL_WEIGHT, 0, 0},
        '{OP_BACKWARD,    4'd0,  4'd0,  16'sd0,      GSEL_WEIGHT, 0, 0},
        '{OP_READ_GRAD,   4'd3,  4'd5,  16'sd0,      GSEL_WEIGHT, 0, 0},
        '{OP_READ_GRAD,   4'd9,  4'd0,  16'sd0,      GSEL_BIAS,   0, 0},
        '{OP_READ_GRAD,   4'd0,  4'd2,  16'sd0,      GSEL_INPUT,  0, 0},
        '{OP_READ_GRAD,   4'd15, 4'd15, 16'sd0,      GSEL_NONE,   1, 0},
        '{OP_CLEAR_GRADS, 4'd0,  4'd0,  16'sd0,      GSEL_WEIGHT, 0, 0},
        '{OP_READ_GRAD,   4'd3,  4'd5,  16'sd0,      GSEL_WEIGHT, 1, 0}
    };

    initial
    begin
        int               pick;
        op_t              op;
        logic signed [15:0] v;
        int               waited;
        start       = 1'b0;
        operation   = '0;
        row_index   = '0;
        col_index   = '0;
        value       = '0;
        grad_select = '0;
        rst_n       = 1'b0;
        error_count = 0;
        items_sent  = 0;
        idle_pct    = 0;
        for (int k = 0; k < 256; k++)
            exp_lut[k] = neg_exp_entry(k);
        for (int j = 0; j < N * N; j++)
        begin
            wg_mem[j] = 0;
            if (j < N)
            begin
                y_mem[j] = 0;
                bg_mem[j] = 0;
                xg_mem[j] = 0;
            end
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store so no entry is read before it is written
        for (int j = 0; j < N * N; j++)
            issue_item(OP_WEIGHT, 4'(j / N), 4'(j % N), 16'($urandom_range(0, 65535)),
                       GSEL_WEIGHT);
        for (int j = 0; j < N; j++)
        begin
            issue_item(OP_BIAS, 4'(j), 4'd0, 16'($urandom_range(0, 65535)), GSEL_WEIGHT);
            issue_item(OP_INPUT, 4'd0, 4'(j), 16'($urandom_range(0, 65535)), GSEL_WEIGHT);
        end
        for (int j = 0; j < H; j++)
            issue_item(OP_TARGET, 4'(j), 4'd0, 16'($urandom_range(0, 65535)), GSEL_WEIGHT);

        foreach (directed_rows[i])
        begin
            issue_item(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
                       directed_rows[i].val, directed_rows[i].sel);
            // fixed rows override the predicted value with the one read off by hand
            if (directed_rows[i].fixed)
            begin
                pending_results.pop_back();
                push_result(KIND_GRAD, 4'd0, directed_rows[i].fixed_val, 1'b1);
            end
        end

        for (int n = 0; n < RAND_CNT; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = OP_WEIGHT;
            else if (pick < 46)
                op = OP_BIAS;
            else if (pick < 54)
                op = OP_INPUT;
            else if (pick < 62)
                op = OP_TARGET;
            else if (pick < 70)
                op = OP_FORWARD;
            else if (pick < 78)
                op = OP_BACKWARD;
            else if (pick < 96)
                op = OP_READ_GRAD;
            else
                op = OP_CLEAR_GRADS;
            // small values keep log variances inside the table now and then
            if ($urandom_range(0, 1))
                v = 16'($urandom_range(0, 65535));
            else
                v = 16'($urandom_range(0, 4095) - 2048);
            issue_item(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), v,
                       2'($urandom_range(0, 3)));
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
